FILE: rtl/frame_bitmap_allocator_top_assert.svh
// Assertion macros for the frame bitmap allocator checker.
`ifndef FRAME_BITMAP_ALLOCATOR_TOP_ASSERT_SVH
`define FRAME_BITMAP_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, idle during reset.
`define FBA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frame bitmap allocator check failed");

// Next-cycle implication.
`define FBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frame bitmap allocator check failed");

`endif

FILE: rtl/fba_pkg.sv
// Types, codes and sizes of the frame bitmap allocator.
package fba_pkg;

    localparam int MAX_FRAMES = 4096;
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int CNT_W      = FRAME_W + 1;

    // Per-frame state codes
    localparam logic [1:0] ST_FREE     = 2'b00;
    localparam logic [1:0] ST_USED     = 2'b01;
    localparam logic [1:0] ST_RESERVED = 2'b10;

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_RESERVE = 2'd2,
        REQ_READ    = 2'd3
    } t_req_type;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_REL,
        S_RES,
        S_READ,
        S_RDATA
    } t_state;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [FRAME_W-1:0] start_frame;
        logic [CNT_W-1:0] end_frame;
        logic [CNT_W-1:0] count;
    } t_req;

    typedef struct packed {
        logic               status;
        logic [FRAME_W-1:0] alloc_frame;
        logic [1:0]         entry_state;
    } t_result;

    typedef struct packed {
        logic               en;
        logic [FRAME_W-1:0] addr;
        logic [1:0]         data;
    } t_mem_wr;

endpackage

FILE: rtl/fba_mem.sv
// Frame state memory: one write port, one registered read port.
module fba_mem
    import fba_pkg::*;
(
    input  logic               i_clk,
    input  t_mem_wr            i_wr,
    input  logic [FRAME_W-1:0] i_raddr,
    output logic [1:0]         o_rdata
);

    logic [1:0] r_mem [MAX_FRAMES];
    logic [1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/fba_ctrl.sv
// Request sequencer: clear pass, first-fit scan, mark, release, reserve and read.
module fba_ctrl
    import fba_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_req               i_req,
    input  logic [CNT_W-1:0]   i_total,
    input  logic [1:0]         i_rdata,
    output t_mem_wr            o_wr,
    output logic [FRAME_W-1:0] o_raddr,
    output logic               o_busy,
    output logic               o_done,
    output t_result            o_res
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_addr, n_addr;
    logic [CNT_W-1:0]   r_last, n_last;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_run, n_run;
    logic               r_pend, n_pend;
    logic [FRAME_W-1:0] r_chk, n_chk;
    logic [FRAME_W-1:0] r_first, n_first;
    logic               r_done, n_done;
    t_result            r_res, n_res;

    logic               addr_lt;
    logic               clear_end;
    logic [CNT_W-1:0]   run_nx;
    logic               found;
    logic [CNT_W-1:0]   alloc_limit;
    logic [CNT_W-1:0]   rel_sum;
    logic [CNT_W-1:0]   rel_last;
    logic [CNT_W:0]     res_endp1;
    logic [CNT_W-1:0]   res_last;
    logic [CNT_W-1:0]   first_full;

    assign addr_lt   = r_addr < r_last;
    assign clear_end = r_addr == CNT_W'(MAX_FRAMES - 1);
    assign run_nx    = (i_rdata == ST_FREE) ? r_run + CNT_W'(1) : '0;
    assign found     = r_pend && (run_nx == r_count);
    assign first_full = {1'b0, r_chk} + CNT_W'(1) - r_count;

    // Scan limit: zero or past the total means the total
    assign alloc_limit = (i_req.end_frame == '0 || i_req.end_frame > i_total)
                       ? i_total : i_req.end_frame;
    assign rel_sum  = {1'b0, i_req.start_frame} + i_req.count;
    assign rel_last = ({1'b0, i_req.start_frame} >= i_total) ? '0
                    : (rel_sum > i_total) ? i_total : rel_sum;
    assign res_endp1 = {1'b0, i_req.end_frame} + (CNT_W + 1)'(1);
    assign res_last  = (res_endp1 > {1'b0, i_total}) ? i_total : res_endp1[CNT_W-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (clear_end) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    case (t_req_type'(i_req.req_type))
                        REQ_ALLOC: begin
                            n_state = (i_req.count == '0) ? S_IDLE : S_SCAN;
                        end
                        REQ_RELEASE: n_state = S_REL;
                        REQ_RESERVE: n_state = S_RES;
                        REQ_READ:    n_state = S_READ;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (found) begin
                    n_state = S_MARK;
                end else if (!r_pend && !addr_lt) begin
                    n_state = S_IDLE;
                end
            end
            S_MARK: begin
                if (!addr_lt) begin
                    n_state = S_IDLE;
                end
            end
            S_REL: begin
                if (!r_pend && !addr_lt) begin
                    n_state = S_IDLE;
                end
            end
            S_RES: begin
                if (!addr_lt) begin
                    n_state = S_IDLE;
                end
            end
            S_READ:  n_state = S_RDATA;
            S_RDATA: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        n_addr  = r_addr;
        n_last  = r_last;
        n_count = r_count;
        n_run   = r_run;
        n_pend  = 1'b0;
        n_chk   = r_chk;
        n_first = r_first;
        n_done  = 1'b0;
        n_res   = r_res;
        o_wr    = '{en: 1'b0, addr: r_addr[FRAME_W-1:0], data: ST_FREE};
        o_raddr = r_addr[FRAME_W-1:0];
        case (r_state)
            S_CLEAR: begin
                o_wr.en = 1'b1;
                n_addr  = clear_end ? '0 : r_addr + CNT_W'(1);
            end
            S_IDLE: begin
                if (i_start) begin
                    n_addr  = {1'b0, i_req.start_frame};
                    n_count = i_req.count;
                    n_run   = '0;
                    n_res   = '0;
                    case (t_req_type'(i_req.req_type))
                        REQ_ALLOC: begin
                            n_last = alloc_limit;
                            if (i_req.count == '0) begin
                                n_done     = 1'b1;
                                n_res.status = 1'b1;
                            end
                        end
                        REQ_RELEASE: n_last = rel_last;
                        REQ_RESERVE: n_last = res_last;
                        default:     n_last = r_last;
                    endcase
                end
            end
            S_SCAN: begin
                n_pend = addr_lt;
                n_chk  = r_addr[FRAME_W-1:0];
                if (addr_lt) begin
                    n_addr = r_addr + CNT_W'(1);
                end
                if (r_pend) begin
                    n_run = run_nx;
                end
                if (found) begin
                    // Drop the read in flight and rewind to the run start
                    n_pend  = 1'b0;
                    n_first = first_full[FRAME_W-1:0];
                    n_addr  = {1'b0, first_full[FRAME_W-1:0]};
                    n_last  = {1'b0, r_chk} + CNT_W'(1);
                end else if (!r_pend && !addr_lt) begin
                    n_done       = 1'b1;
                    n_res.status = 1'b1;
                end
            end
            S_MARK: begin
                if (addr_lt) begin
                    o_wr.en   = 1'b1;
                    o_wr.data = ST_USED;
                    n_addr    = r_addr + CNT_W'(1);
                end else begin
                    n_done            = 1'b1;
                    n_res.alloc_frame = r_first;
                end
            end
            S_REL: begin
                n_pend = addr_lt;
                n_chk  = r_addr[FRAME_W-1:0];
                if (addr_lt) begin
                    n_addr = r_addr + CNT_W'(1);
                end
                // Free only used frames, leave reserved ones
                if (r_pend && i_rdata == ST_USED) begin
                    o_wr.en   = 1'b1;
                    o_wr.addr = r_chk;
                    o_wr.data = ST_FREE;
                end
                if (!r_pend && !addr_lt) begin
                    n_done = 1'b1;
                end
            end
            S_RES: begin
                if (addr_lt) begin
                    o_wr.en   = 1'b1;
                    o_wr.data = ST_RESERVED;
                    n_addr    = r_addr + CNT_W'(1);
                end else begin
                    n_done = 1'b1;
                end
            end
            S_READ: begin
                o_raddr = r_addr[FRAME_W-1:0];
            end
            S_RDATA: begin
                n_done            = 1'b1;
                n_res.entry_state = i_rdata;
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last  <= n_last;
        r_count <= n_count;
        r_run   <= n_run;
        r_chk   <= n_chk;
        r_first <= n_first;
        r_res   <= n_res;
    end

    assign o_busy = r_state != S_IDLE;
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

FILE: rtl/frame_bitmap_allocator_top.sv
// Frame bitmap allocator: first-fit allocation over a 2-bit-per-frame state map.
//
// Request channel: drive i_req and raise start; the request is taken on a
// clock edge where start is high and busy is low. Exactly one result per
// request appears on o_res for one cycle with o_done high; the receiver
// must take it then, there is no back-pressure.
// Configuration: i_cfg_data sets total_frames on a beat where i_cfg_valid
// is high; o_cfg_ready is always high. Write it only while the block is idle.
// Sequencing, set by the single read and single write port of the frame map:
//   read entry: the address is presented, then the registered entry is returned
//   reserve: each frame in the range is written reserved
//   release: each frame in the range is read, used ones are written free
//   allocate: a first-fit scan reads for a run of count free frames; once found,
//     the run is marked used; a zero count skips the scan, busy stays low.
// A new request may start on the cycle the result is shown.
// Reset: total_frames returns to 4096 and a clearing pass sets every frame
// free, one frame per cycle, with busy high.
module frame_bitmap_allocator_top
    import fba_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  t_req             i_req,
    output logic             busy,
    output logic             o_done,
    output t_result          o_res,
    input  logic             i_cfg_valid,
    input  logic [CNT_W-1:0] i_cfg_data,
    output logic             o_cfg_ready
);

    logic [CNT_W-1:0]   r_total_frames;
    logic [CNT_W-1:0]   eff_total;
    t_mem_wr            mem_wr;
    logic [FRAME_W-1:0] mem_raddr;
    logic [1:0]         mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_frames <= CNT_W'(MAX_FRAMES);
        end else if (i_cfg_valid) begin
            r_total_frames <= i_cfg_data;
        end
    end

    // Saturate the configured total at the map size
    assign eff_total = (r_total_frames > CNT_W'(MAX_FRAMES))
                     ? CNT_W'(MAX_FRAMES) : r_total_frames;
    assign o_cfg_ready = 1'b1;

    fba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (i_req),
        .i_total (eff_total),
        .i_rdata (mem_rdata),
        .o_wr    (mem_wr),
        .o_raddr (mem_raddr),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    fba_mem u_mem (
        .i_clk   (i_clk),
        .i_wr    (mem_wr),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

FILE: rtl/fba_checker.sv
// Port-level checks on the frame bitmap allocator, bound to the top level.
`include "frame_bitmap_allocator_top_assert.svh"

module fba_checker
    import fba_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_done,
    input t_result o_res
);

    // A zero-count allocate answers at once without raising busy
    `FBA_ASSERT_NEXT(a_take_sets_busy, start && !busy, busy || o_done)
    `FBA_ASSERT_NOW(a_done_idle, o_done, !busy)
    `FBA_ASSERT_NOW(a_done_after_take, o_done, $past(busy || start))
    `FBA_ASSERT_NOW(a_fail_no_frame, o_done && o_res.status, o_res.alloc_frame == '0)

endmodule

bind frame_bitmap_allocator_top fba_checker u_fba_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_res   (o_res)
);
